// ===== sv/lbof_pkg.sv =====
// Line break opportunity finder: shared package.
// Holds the dense line-break class codes and the rule result type.
// No dependencies.
package lbof_pkg;

   typedef logic [5:0] class_type;

   localparam class_type C_XX = 6'd0;
   localparam class_type C_BK = 6'd1;
   localparam class_type C_CR = 6'd2;
   localparam class_type C_LF = 6'd3;
   localparam class_type C_NL = 6'd4;
   localparam class_type C_SP = 6'd5;
   localparam class_type C_ZW = 6'd6;
   localparam class_type C_CM = 6'd7;
   localparam class_type C_WJ = 6'd8;
   localparam class_type C_GL = 6'd9;
   localparam class_type C_CL = 6'd10;
   localparam class_type C_EX = 6'd11;
   localparam class_type C_IS = 6'd12;
   localparam class_type C_SY = 6'd13;
   localparam class_type C_OP = 6'd14;
   localparam class_type C_QU = 6'd15;
   localparam class_type C_NS = 6'd16;
   localparam class_type C_B2 = 6'd17;
   localparam class_type C_CB = 6'd18;
   localparam class_type C_BA = 6'd19;
   localparam class_type C_HY = 6'd20;
   localparam class_type C_BB = 6'd21;
   localparam class_type C_IN = 6'd22;
   localparam class_type C_AL = 6'd23;
   localparam class_type C_ID = 6'd24;
   localparam class_type C_NU = 6'd25;
   localparam class_type C_PO = 6'd26;
   localparam class_type C_PR = 6'd27;
   localparam class_type C_JL = 6'd28;
   localparam class_type C_JV = 6'd29;
   localparam class_type C_JT = 6'd30;
   localparam class_type C_H2 = 6'd31;
   localparam class_type C_H3 = 6'd32;
   localparam class_type C_LAST = C_H3;

   // Register index of the hyphen option rule enable
   localparam logic REG_HYPHEN_EN = 1'b0;

   // Outcome of one pair decision
   typedef struct packed {
      logic      brk;
      class_type keep;
   } decision_type;

   // Context that the rule network needs besides the pair itself
   typedef struct packed {
      class_type ind;
      logic      two_back_sp;
      logic      hyphen_en;
   } context_type;

endpackage

// ===== sv/lbof_rules.sv =====
// Line break opportunity finder: pair rule network (LB4 to LB31).
// Purely combinational; depends on lbof_pkg.
module lbof_rules (
   input  lbof_pkg::class_type    prev_cls,
   input  lbof_pkg::class_type    cur_cls,
   input  lbof_pkg::context_type  ctx,
   output lbof_pkg::decision_type decision
);

   function automatic logic is_hard(input lbof_pkg::class_type c);
      return c == lbof_pkg::C_BK || c == lbof_pkg::C_CR ||
             c == lbof_pkg::C_LF || c == lbof_pkg::C_NL;
   endfunction

   function automatic logic is_hangul(input lbof_pkg::class_type c);
      return c >= lbof_pkg::C_JL && c <= lbof_pkg::C_H3;
   endfunction

   lbof_pkg::class_type b;
   lbof_pkg::class_type a;
   lbof_pkg::class_type ind;

   assign b   = prev_cls;
   assign a   = cur_cls;
   assign ind = ctx.ind;

   always_comb begin
      decision.keep = a;
      decision.brk  = 1'b1;
      priority if (b == lbof_pkg::C_BK) begin
         decision.brk = 1'b1;
      end else if (b == lbof_pkg::C_CR && a == lbof_pkg::C_LF) begin
         decision.brk = 1'b0;
      end else if (b == lbof_pkg::C_CR || b == lbof_pkg::C_LF || b == lbof_pkg::C_NL) begin
         decision.brk = 1'b1;
      end else if (is_hard(a)) begin
         decision.brk = 1'b0;
      end else if (a == lbof_pkg::C_SP || a == lbof_pkg::C_ZW) begin
         decision.brk = 1'b0;
      end else if (b == lbof_pkg::C_ZW) begin
         decision.brk = 1'b1;
      end else if (a == lbof_pkg::C_CM) begin
         // mark takes its base class; after a space it counts as alphabetic
         decision.keep = (is_hard(b) || b == lbof_pkg::C_SP || b == lbof_pkg::C_ZW) ?
                         lbof_pkg::C_AL : b;
         decision.brk  = 1'b0;
      end else if (b == lbof_pkg::C_WJ || a == lbof_pkg::C_WJ) begin
         decision.brk = 1'b0;
      end else if (b != lbof_pkg::C_SP && a == lbof_pkg::C_GL) begin
         decision.brk = 1'b0;
      end else if (b == lbof_pkg::C_GL) begin
         decision.brk = 1'b0;
      end else if (a == lbof_pkg::C_CL || a == lbof_pkg::C_EX ||
                   a == lbof_pkg::C_IS || a == lbof_pkg::C_SY) begin
         decision.brk = 1'b0;
      end else if (ind == lbof_pkg::C_OP) begin
         decision.brk = 1'b0;
      end else if (ind == lbof_pkg::C_QU && a == lbof_pkg::C_OP) begin
         decision.brk = 1'b0;
      end else if (ind == lbof_pkg::C_CL && a == lbof_pkg::C_NS) begin
         decision.brk = 1'b0;
      end else if (ind == lbof_pkg::C_B2 && a == lbof_pkg::C_B2) begin
         decision.brk = 1'b0;
      end else if (b == lbof_pkg::C_SP) begin
         decision.brk = 1'b1;
      end else if (b == lbof_pkg::C_QU || a == lbof_pkg::C_QU) begin
         decision.brk = 1'b0;
      end else if (a == lbof_pkg::C_CB || b == lbof_pkg::C_CB) begin
         decision.brk = 1'b1;
      end else if (a == lbof_pkg::C_BA || a == lbof_pkg::C_HY ||
                   a == lbof_pkg::C_NS || b == lbof_pkg::C_BB) begin
         decision.brk = 1'b0;
      end else if (a == lbof_pkg::C_IN &&
                   (b == lbof_pkg::C_AL || b == lbof_pkg::C_ID ||
                    b == lbof_pkg::C_IN || b == lbof_pkg::C_NU)) begin
         decision.brk = 1'b0;
      end else if ((b == lbof_pkg::C_ID && a == lbof_pkg::C_PO) ||
                   (b == lbof_pkg::C_AL && a == lbof_pkg::C_NU) ||
                   (b == lbof_pkg::C_NU && a == lbof_pkg::C_AL)) begin
         decision.brk = 1'b0;
      end else if (b == lbof_pkg::C_PR && (a == lbof_pkg::C_ID || a == lbof_pkg::C_AL)) begin
         decision.brk = 1'b0;
      end else if (b == lbof_pkg::C_PO && a == lbof_pkg::C_AL) begin
         decision.brk = 1'b0;
      end else if ((b == lbof_pkg::C_CL || b == lbof_pkg::C_NU) &&
                   (a == lbof_pkg::C_PO || a == lbof_pkg::C_PR)) begin
         decision.brk = 1'b0;
      end else if ((b == lbof_pkg::C_PO || b == lbof_pkg::C_PR) &&
                   (a == lbof_pkg::C_OP || a == lbof_pkg::C_NU)) begin
         decision.brk = 1'b0;
      end else if ((b == lbof_pkg::C_HY || b == lbof_pkg::C_IS ||
                    b == lbof_pkg::C_NU || b == lbof_pkg::C_SY) && a == lbof_pkg::C_NU) begin
         decision.brk = 1'b0;
      end else if (b == lbof_pkg::C_JL &&
                   (a == lbof_pkg::C_JL || a == lbof_pkg::C_JV ||
                    a == lbof_pkg::C_H2 || a == lbof_pkg::C_H3)) begin
         decision.brk = 1'b0;
      end else if ((b == lbof_pkg::C_JV || b == lbof_pkg::C_H2) &&
                   (a == lbof_pkg::C_JV || a == lbof_pkg::C_JT)) begin
         decision.brk = 1'b0;
      end else if ((b == lbof_pkg::C_JT || b == lbof_pkg::C_H3) && a == lbof_pkg::C_JT) begin
         decision.brk = 1'b0;
      end else if (is_hangul(b) && (a == lbof_pkg::C_IN || a == lbof_pkg::C_PO)) begin
         decision.brk = 1'b0;
      end else if (b == lbof_pkg::C_PR && is_hangul(a)) begin
         decision.brk = 1'b0;
      end else if (b == lbof_pkg::C_AL && a == lbof_pkg::C_AL) begin
         decision.brk = 1'b0;
      end else if (b == lbof_pkg::C_IS && a == lbof_pkg::C_AL) begin
         decision.brk = 1'b0;
      end else if ((b == lbof_pkg::C_AL || b == lbof_pkg::C_NU) && a == lbof_pkg::C_OP) begin
         decision.brk = 1'b0;
      end else if (b == lbof_pkg::C_CL && (a == lbof_pkg::C_AL || a == lbof_pkg::C_NU)) begin
         decision.brk = 1'b0;
      end else if (ctx.hyphen_en && b == lbof_pkg::C_HY && a != lbof_pkg::C_SP &&
                   ctx.two_back_sp) begin
         decision.brk = 1'b0;
      end else begin
         decision.brk = 1'b1;
      end
   end

endmodule

// ===== sv/line_break_opportunity_finder.sv =====
// Line break opportunity finder: top level with stream ports and CSR port.
// Depends on lbof_pkg and lbof_rules.
//
//  channel  direction  handshake                       payload
//  req_     in         req_tvalid / req_tready          tdata: line_class; tuser: start_of_text
//  rsp_     out        rsp_tvalid / rsp_tready          tdata: break_before
//  csr_     in         psel, penable, pwrite, pready    hyphen_option_rule_enable at 0x0
//
// One request per cycle unless the result stalls; the answer sits in the
// result register the cycle after the request is taken. The rate is set by
// the rule network, combinational between request port and result register.
// Reset (synchronous) clears the history to space, the text count to zero,
// the hyphen option rule to enabled and the result register to empty.
// A stalled result holds; a new request is still taken in the cycle that
// the result leaves.
module line_break_opportunity_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] line_class, [7:6] zero
   input  logic        req_tuser,   // [0] start_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] break_before, [7:1] zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration register
   logic hyphen_en_ff;
   logic hyphen_en_in;

   // Character history
   lbof_pkg::class_type prev_ff,  prev_in;
   lbof_pkg::class_type prev2_ff, prev2_in;
   lbof_pkg::class_type ind_ff,   ind_in;
   logic [1:0]          seen_ff,  seen_in;

   // Result register
   logic rsp_valid_ff, rsp_valid_in;
   logic brk_ff, brk_in;

   logic                   req_accept;
   logic                   csr_write;
   logic                   start;
   lbof_pkg::class_type    cls;
   lbof_pkg::class_type    ind_eff;
   lbof_pkg::context_type  ctx;
   lbof_pkg::decision_type decision;

   // --- CSR port: always ready, register at word 0 ---
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == lbof_pkg::REG_HYPHEN_EN) ?
                       {31'd0, hyphen_en_ff} : 32'd0;

   always_comb begin
      hyphen_en_in = hyphen_en_ff;
      if (csr_write && csr_paddr[2] == lbof_pkg::REG_HYPHEN_EN) begin
         hyphen_en_in = csr_pwdata[0];
      end
   end

   // --- request side: take a request whenever the result slot frees up ---
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // Fold unused codes onto the other class
   assign cls = (req_tdata[5:0] > lbof_pkg::C_LAST) ? lbof_pkg::C_XX : req_tdata[5:0];

   // Without a text under way every character starts one
   assign start = req_tuser || (seen_ff == 2'd0);

   // Last non-space class, including the previous character
   assign ind_eff = (prev_ff != lbof_pkg::C_SP) ? prev_ff : ind_ff;

   assign ctx.ind         = ind_eff;
   assign ctx.two_back_sp = (seen_ff == 2'd2) && (prev2_ff == lbof_pkg::C_SP);
   assign ctx.hyphen_en   = hyphen_en_ff;

   lbof_rules u_rules (
      .prev_cls (prev_ff),
      .cur_cls  (cls),
      .ctx      (ctx),
      .decision (decision)
   );

   // --- history update and result capture ---
   always_comb begin
      prev_in      = prev_ff;
      prev2_in     = prev2_ff;
      ind_in       = ind_ff;
      seen_in      = seen_ff;
      brk_in       = brk_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         if (start) begin
            // restart history; a leading mark stands as alphabetic
            brk_in   = 1'b0;
            prev_in  = (cls == lbof_pkg::C_CM) ? lbof_pkg::C_AL : cls;
            prev2_in = lbof_pkg::C_SP;
            ind_in   = lbof_pkg::C_SP;
            seen_in  = 2'd1;
         end else begin
            brk_in   = decision.brk;
            prev_in  = decision.keep;
            prev2_in = prev_ff;
            ind_in   = ind_eff;
            seen_in  = (seen_ff == 2'd2) ? seen_ff : seen_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hyphen_en_ff <= 1'b1;
         prev_ff      <= lbof_pkg::C_SP;
         prev2_ff     <= lbof_pkg::C_SP;
         ind_ff       <= lbof_pkg::C_SP;
         seen_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hyphen_en_ff <= hyphen_en_in;
         prev_ff      <= prev_in;
         prev2_ff     <= prev2_in;
         ind_ff       <= ind_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      brk_ff <= brk_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, brk_ff};

endmodule
